// ===== rtl/lqs_pkg.sv =====
// Package for the linear queue with search block.
// Holds field types, operation codes and status codes; depends on nothing.
`timescale 1ns / 1ps

package lqs_pkg;

  localparam int OP_W   = 2;
  localparam int DATA_W = 32;
  localparam int ST_W   = 3;
  localparam int CAP_W  = 5;

  typedef logic [OP_W-1:0]          op_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ST_W-1:0]          status_t;
  typedef logic [CAP_W-1:0]         cap_t;

  localparam op_t OP_ENQ    = 2'd0;
  localparam op_t OP_DEQ    = 2'd1;
  localparam op_t OP_SEARCH = 2'd2;
  localparam op_t OP_READ   = 2'd3;

  localparam status_t ST_DONE     = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_EMPTY    = 3'd2;
  localparam status_t ST_FOUND    = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;

  localparam cap_t CAP_RESET = 5'd16;

endpackage

// ===== rtl/lqs_in_if.sv =====
// Input channel interface: valid, ready and one request beat (op, value).
// Depends on lqs_pkg.
`timescale 1ns / 1ps

interface lqs_in_if;
  import lqs_pkg::*;

  logic  valid;
  logic  ready;
  op_t   op;
  data_t value;

  modport source(output valid, output op, output value, input ready);
  modport sink(input valid, input op, input value, output ready);
endinterface

// ===== rtl/lqs_out_if.sv =====
// Result channel interface: valid, ready and one result beat (status, data, last).
// Depends on lqs_pkg.
`timescale 1ns / 1ps

interface lqs_out_if;
  import lqs_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  data_t   data;
  logic    last;

  modport source(output valid, output status, output data, output last, input ready);
  modport sink(input valid, input status, input data, input last, output ready);
endinterface

// ===== rtl/lqs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; the read data holds while the read enable is low.
`timescale 1ns / 1ps

module lqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/lqs_ctrl.sv =====
// Sequencer of the queue: head and tail pointers, one shared key comparator,
// the scan walk over the slot RAM and the output register. Depends on lqs_pkg,
// lqs_in_if and lqs_out_if; drives the ports of an lqs_ram instance.
`timescale 1ns / 1ps

module lqs_ctrl #(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lqs_pkg::cap_t     capacity,
  lqs_in_if.sink            in_ch,
  lqs_out_if.source         out_ch,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output lqs_pkg::data_t    ram_wdata,
  output logic              ram_re,
  output logic [AW-1:0]     ram_raddr,
  input  lqs_pkg::data_t    ram_rdata
);
  import lqs_pkg::*;

  localparam int PW   = $clog2(DEPTH + 1);
  localparam int CMPW = (PW > CAP_W) ? PW : CAP_W;
  localparam logic [PW-1:0]   P_ONE   = PW'(1);
  localparam logic [PW-1:0]   P_ZERO  = PW'(0);
  localparam logic [CMPW-1:0] DEPTH_X = CMPW'(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_GET  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [PW-1:0] idx_r, idx_nxt;
  op_t           op_r, op_nxt;
  data_t         key_r, key_nxt;
  logic          hit_r, hit_nxt;
  logic          cmp_v_r, cmp_v_nxt;
  logic          cmp_last_r, cmp_last_nxt;
  status_t       res_status_r, res_status_nxt;
  data_t         res_data_r, res_data_nxt;
  logic          res_last_r, res_last_nxt;
  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  data_t         out_data_r, out_data_nxt;
  logic          out_last_r, out_last_nxt;

  logic [PW-1:0]   idx_inc;
  logic [CMPW-1:0] tail_x;
  logic [CMPW-1:0] cap_x;
  logic            full;
  logic            empty;
  logic            out_free;
  logic            key_match;

  assign idx_inc   = idx_r + P_ONE;
  assign tail_x    = CMPW'(tail_r);
  assign cap_x     = CMPW'(capacity);
  assign full      = (tail_x >= cap_x) || (tail_x >= DEPTH_X);
  assign empty     = head_r >= tail_r;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign key_match = ram_rdata == key_r;

  assign in_ch.ready   = state_r == S_IDLE;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.data   = out_data_r;
  assign out_ch.last   = out_last_r;

  assign ram_waddr = tail_r[AW-1:0];
  assign ram_wdata = in_ch.value;
  assign ram_raddr = idx_r[AW-1:0];

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    idx_nxt        = idx_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    hit_nxt        = hit_r;
    cmp_v_nxt      = cmp_v_r;
    cmp_last_nxt   = cmp_last_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    res_last_nxt   = res_last_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt       = in_ch.op;
          key_nxt      = in_ch.value;
          idx_nxt      = head_r;
          hit_nxt      = 1'b0;
          cmp_v_nxt    = 1'b0;
          cmp_last_nxt = 1'b0;
          res_data_nxt = '0;
          res_last_nxt = 1'b1;
          case (in_ch.op)
            OP_ENQ: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_we         = 1'b1;
                tail_nxt       = tail_r + P_ONE;
                res_status_nxt = ST_DONE;
              end
              state_nxt = S_PUT;
            end
            default: begin
              if (empty) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_PUT;
              end else if (in_ch.op == OP_SEARCH) begin
                state_nxt = S_SCAN;
              end else begin
                state_nxt = S_RD;
              end
            end
          endcase
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_GET;
      end
      S_GET: begin
        res_status_nxt = ST_DONE;
        res_data_nxt   = ram_rdata;
        res_last_nxt   = (op_r == OP_READ) ? (idx_inc == tail_r) : 1'b1;
        if (op_r == OP_DEQ) begin
          if (head_r == P_ZERO && tail_r == P_ONE) begin
            head_nxt = P_ZERO;
            tail_nxt = P_ZERO;
          end else begin
            head_nxt = head_r + P_ONE;
          end
        end
        state_nxt = S_PUT;
      end
      S_SCAN: begin
        if (idx_r < tail_r) begin
          ram_re       = 1'b1;
          idx_nxt      = idx_inc;
          cmp_v_nxt    = 1'b1;
          cmp_last_nxt = idx_inc == tail_r;
        end else begin
          cmp_v_nxt = 1'b0;
        end
        if (cmp_v_r) begin
          hit_nxt = hit_r | key_match;
          if (cmp_last_r) begin
            res_status_nxt = (hit_r | key_match) ? ST_FOUND : ST_NOTFOUND;
            state_nxt      = S_PUT;
          end
        end
      end
      S_PUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_data_nxt   = res_data_r;
          out_last_nxt   = res_last_r;
          if (op_r == OP_READ && !res_last_r) begin
            idx_nxt   = idx_inc;
            state_nxt = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    hit_r        <= hit_nxt;
    cmp_v_r      <= cmp_v_nxt;
    cmp_last_r   <= cmp_last_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    res_last_r   <= res_last_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

// ===== rtl/linear_queue_with_search_unit.sv =====
// Top level of the linear queue with search: capacity register, sequencer
// and slot RAM. Depends on lqs_pkg, lqs_in_if, lqs_out_if, lqs_ram, lqs_ctrl.
//
// Usage: each request beat on in_ch carries an op (enqueue, dequeue, search,
// read out) and a value. Result beats leave on out_ch with status, data and
// a last flag; only a read out of a non-empty queue gives several beats, one
// per live entry. The capacity register is written through cfg_we/cfg_wdata by the
// user only while the block is idle; the block does not enforce it. Fill stops at DEPTH.
// Flow: a full or successful enqueue and every empty result go from acceptance
// straight to the output stage, which registers the beat, and the sequencer then
// returns to idle. A dequeue goes through RAM read, capture and output register
// before the sequencer takes the next request. A search walks the live entries
// through the one RAM read port and the shared key comparator, one entry per
// cycle, and then registers its found or not-found beat. A read out takes each
// entry through RAM read, capture and output register.
// in_ch.ready is high only while the sequencer is idle, so one request is in
// work at a time. When the receiver stalls, the output register holds its beat
// and the sequencer waits before loading the next one; nothing is dropped.
// Reset clears both pointers, the output valid and sets the capacity to 16;
// the slot RAM is not cleared, as only written slots are ever read.
`timescale 1ns / 1ps

module linear_queue_with_search_unit #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  lqs_in_if.sink        in_ch,
  lqs_out_if.source     out_ch,
  input  logic          cfg_we,
  input  lqs_pkg::cap_t cfg_wdata
);
  import lqs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cap_t cap_r, cap_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  data_t         ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  data_t         ram_rdata;

  always_comb begin
    cap_nxt = cap_r;
    if (cfg_we) begin
      cap_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  lqs_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .capacity  (cap_r),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  lqs_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

endmodule

// ===== tb/tb_linear_queue_with_search_unit.sv =====
// Self-checking testbench for linear_queue_with_search_unit.
// Predicts every result beat from its own model of the queue and checks the beats in order.
// Depends on lqs_pkg, lqs_in_if, lqs_out_if and the unit itself.
`timescale 1ns / 1ps

module tb_linear_queue_with_search_unit;
  import lqs_pkg::*;

  localparam int QUEUE_DEPTH   = 16;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    status_t status;
    data_t   data;
    logic    last;
  } result_beat_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cap_t cfg_wdata;

  lqs_in_if  in_ch();
  lqs_out_if out_ch();

  linear_queue_with_search_unit #(.DEPTH(QUEUE_DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  cap_t         model_cap;
  int unsigned  model_head;
  int unsigned  model_tail;
  data_t        model_slots [QUEUE_DEPTH];
  result_beat_t queue_responses [$];

  int error_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int unsigned usable_capacity();
    return (model_cap > QUEUE_DEPTH) ? QUEUE_DEPTH : model_cap;
  endfunction

  function automatic result_beat_t make_beat(status_t status, data_t data, logic last);
    result_beat_t beat;
    beat.status = status;
    beat.data   = data;
    beat.last   = last;
    return beat;
  endfunction

  task automatic predict_queue_response(input op_t op, input data_t value);
    logic hit;
    hit = 1'b0;
    if (op == OP_ENQ) begin
      if (model_tail >= usable_capacity() || model_tail >= QUEUE_DEPTH) begin
        queue_responses.push_back(make_beat(ST_FULL, '0, 1'b1));
      end else begin
        model_slots[model_tail] = value;
        model_tail++;
        queue_responses.push_back(make_beat(ST_DONE, '0, 1'b1));
      end
    end else if (model_head >= model_tail) begin
      queue_responses.push_back(make_beat(ST_EMPTY, '0, 1'b1));
    end else if (op == OP_DEQ) begin
      queue_responses.push_back(make_beat(ST_DONE, model_slots[model_head], 1'b1));
      if (model_head == 0 && model_tail == 1) begin
        model_tail = 0;
      end else begin
        model_head++;
      end
    end else if (op == OP_SEARCH) begin
      for (int unsigned i = model_head; i < model_tail; i++) begin
        if (model_slots[i] == value) hit = 1'b1;
      end
      queue_responses.push_back(make_beat(hit ? ST_FOUND : ST_NOTFOUND, '0, 1'b1));
    end else begin
      for (int unsigned i = model_head; i < model_tail; i++) begin
        queue_responses.push_back(make_beat(ST_DONE, model_slots[i], i + 1 == model_tail));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_queue_response(in_ch.op, in_ch.value);
    end
  end

  always @(posedge clk) begin
    result_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (queue_responses.size() == 0) begin
        $error("unexpected result beat: status %0d, data %0d, last %0d",
               out_ch.status, out_ch.data, out_ch.last);
        error_count++;
      end else begin
        want = queue_responses.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_ch.status);
          error_count++;
        end
        if (out_ch.data !== want.data) begin
          $error("data mismatch: expected %0d, actual %0d", want.data, out_ch.data);
          error_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last mismatch: expected %0d, actual %0d", want.last, out_ch.last);
          error_count++;
        end
      end
    end
  end

  // The receiver drops ready for a whole hold-off stretch before it stalls at random again.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic data_t random_value();
    case ($urandom_range(3))
      0: return data_t'(32'h8000_0000);
      1: return data_t'(32'h7fff_ffff);
      2: return data_t'($urandom_range(7)) - data_t'(2);
      default: return data_t'($urandom);
    endcase
  endfunction

  function automatic data_t pick_key();
    if (model_tail > model_head && $urandom_range(1) == 1) begin
      return model_slots[$urandom_range(model_tail - 1, model_head)];
    end
    return random_value();
  endfunction

  function automatic op_t random_op();
    return op_t'($urandom_range(3));
  endfunction

  task automatic send_request(input op_t op, input data_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random(input op_t op);
    send_request(op, (op == OP_SEARCH) ? pick_key() : random_value());
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (queue_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input cap_t cap);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we    <= 1'b0;
    model_cap = cap;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic test_empty_queue();
    send_request(OP_DEQ, '0);
    send_request(OP_SEARCH, '0);
    send_request(OP_READ, '0);
    wait_drain();
  endtask

  task automatic test_zero_capacity();
    write_capacity(cap_t'(0));
    send_request(OP_ENQ, data_t'(32'h7fff_ffff));
    send_request(OP_ENQ, data_t'(32'h8000_0000));
    wait_drain();
  endtask

  task automatic test_single_slot();
    write_capacity(cap_t'(1));
    send_request(OP_ENQ, data_t'(32'h7fff_ffff));
    send_request(OP_ENQ, data_t'(32'h1234_5678));
    send_request(OP_SEARCH, data_t'(32'h7fff_ffff));
    send_request(OP_SEARCH, data_t'(32'hffff_ffff));
    send_request(OP_READ, '0);
    send_request(OP_DEQ, '0);
    send_request(OP_ENQ, data_t'(32'h8000_0000));
    send_request(OP_READ, '0);
    send_request(OP_DEQ, '0);
    send_request(OP_DEQ, '0);
    wait_drain();
  endtask

  task automatic test_random_single_slot();
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: set_idling(0, 0);
        1: set_idling(54, 0);
        2: set_idling(0, 54);
        default: set_idling(11, 11);
      endcase
      repeat (50) send_random(random_op());
      if (mode == 1) begin
        wait_drain();
        write_capacity(cap_t'(0));
        repeat (15) send_random(random_op());
        wait_drain();
        write_capacity(cap_t'(1));
      end
    end
    wait_drain();
  endtask

  task automatic fill_without_dequeue(input int unsigned target);
    int pick;
    while (model_tail < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_random(OP_ENQ);
      end else if (pick < 85) begin
        send_random(OP_SEARCH);
      end else begin
        send_random(OP_READ);
      end
    end
    send_random(OP_ENQ);
  endtask

  task automatic test_fill_and_drain();
    int pick;
    set_idling(54, 0);
    write_capacity(cap_t'(8));
    fill_without_dequeue(8);
    hold_left = 400;
    repeat (3) begin
      send_random(OP_READ);
      send_random(OP_SEARCH);
    end
    wait_drain();
    write_capacity(cap_t'(31));
    set_idling(11, 11);
    fill_without_dequeue(QUEUE_DEPTH);
    set_idling(0, 54);
    send_request(OP_READ, '0);
    send_request(OP_READ, '0);
    send_request(OP_SEARCH, model_slots[model_head]);
    send_request(OP_SEARCH, model_slots[model_tail - 1]);
    send_random(OP_SEARCH);
    while (model_tail > model_head) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        send_random(OP_DEQ);
      end else if (pick < 75) begin
        send_random(OP_SEARCH);
      end else begin
        send_random(OP_READ);
      end
    end
    send_random(OP_DEQ);
    send_random(OP_SEARCH);
    send_random(OP_READ);
    wait_drain();
  endtask

  task automatic test_capacity_below_tail();
    set_idling(11, 54);
    write_capacity(cap_t'(4));
    repeat (20) send_random(random_op());
    wait_drain();
    write_capacity(CAP_RESET);
    send_random(OP_ENQ);
    send_random(OP_READ);
    wait_drain();
  endtask

  initial begin
    error_count    = 0;
    cycle_count    = 0;
    hold_left      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    model_cap      = CAP_RESET;
    model_head     = 0;
    model_tail     = 0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = CAP_RESET;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_ENQ;
    in_ch.value    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_zero_capacity();
    test_single_slot();
    test_random_single_slot();
    test_fill_and_drain();
    test_capacity_below_tail();

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
